/* rtl/letter_sum_window_search_core_defines.svh */
// ----------------------------------------------------------------------------
// Letter sum window search: assertion macros
// Shared check macros, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LETTER_SUM_WINDOW_SEARCH_CORE_DEFINES_SVH
`define LETTER_SUM_WINDOW_SEARCH_CORE_DEFINES_SVH

`ifndef SYNTH
// Check that is ignored while reset is asserted.
`define LSWS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("letter sum window search check failed");
// Check that must also hold while reset is asserted.
`define LSWS_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("letter sum window search check failed");
`else
`define LSWS_ASSERT(lbl, prop)
`define LSWS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* rtl/lsws_pkg.sv */
// ----------------------------------------------------------------------------
// Letter sum window search package
// Field widths, character constants and the letter value function.
// ----------------------------------------------------------------------------
package lsws_pkg;

	localparam int CHAR_W   = 8;
	localparam int SUM_W    = 10;
	localparam int START_W  = 10;
	localparam int LEN_W    = 6;
	localparam int VAL_W    = 5;

	localparam logic [CHAR_W-1:0] CHAR_UC_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UC_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CHAR_LC_A = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_LC_Z = 8'h7A;

	// Control handed from the top level to every cell of the chain.
	typedef struct packed {
		logic adv;  // a request is taken this cycle
		logic clr;  // that request ends the text
	} lsws_ctl_t;

	// Alphabet position of a letter in either case, zero for anything else.
	function automatic logic [VAL_W-1:0] char_worth(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] d;
		d = '0;
		if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
			d = c - CHAR_UC_A + 8'd1;
		end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
			d = c - CHAR_LC_A + 8'd1;
		end
		return d[VAL_W-1:0];
	endfunction

endpackage

/* rtl/letter_sum_window_search_core.sv */
// A match on a character appears on m_tdata in the cycle after that character is taken.
// Throughput: one character per cycle; all candidate cells update in parallel.
// The only stall comes from a result held in the output register while m_tready is low.
// Reset: arst_n clears the target, the position counter, every candidate and the output.
// ----------------------------------------------------------------------------
// Letter sum window search core
// Reports stretches of text, opened by a letter, whose letter values hit the target.
// ----------------------------------------------------------------------------
`include "letter_sum_window_search_core_defines.svh"

module letter_sum_window_search_core import lsws_pkg::*; #(
	parameter int MAX_LEN  = 32,
	parameter int MAX_TEXT = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration: target_sum
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [SUM_W-1:0]            cfg_data,
	// input stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [CHAR_W-1:0]           s_tdata,    // [7:0] text_char
	input  logic                        s_tlast,    // end_of_text
	// result stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [START_W+LEN_W-1:0]    m_tdata     // [9:0] match_start, [15:10] match_length
);

	localparam int POS_W = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_TEXT - 1);

	logic [SUM_W-1:0]               target_q;
	logic [POS_W-1:0]               pos_q;
	logic                           open;
	logic                           accept;
	logic [VAL_W-1:0]               value;
	lsws_ctl_t                      ctl;

	logic [MAX_LEN-1:0]             act_vec;
	logic [MAX_LEN-1:0][SUM_W-1:0]  sum_vec;
	logic [MAX_LEN-1:0][POS_W-1:0]  start_vec;
	logic [MAX_LEN-1:0][POS_W-1:0]  hit_start_vec;
	logic [MAX_LEN-1:0]             hit_vec;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_valid) begin
			target_q <= cfg_data;
		end
	end

	// The chain moves whenever the output register can take what it produces.
	assign open     = !m_tvalid || m_tready;
	assign s_tready = open;
	assign accept   = s_tvalid && open;
	assign value    = char_worth(s_tdata);
	assign ctl.adv  = accept;
	assign ctl.clr  = s_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (s_tlast || pos_q == POS_MAX) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// Cell k holds the candidate that opened k characters back; a letter opens one at cell 0.
	for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
		logic               p_act;
		logic [SUM_W-1:0]   p_sum;
		logic [POS_W-1:0]   p_start;

		if (k == 0) begin : g_head
			assign p_act   = (value != '0);
			assign p_sum   = '0;
			assign p_start = pos_q;
		end else begin : g_link
			assign p_act   = act_vec[k-1];
			assign p_sum   = sum_vec[k-1];
			assign p_start = start_vec[k-1];
		end

		// A hit in cell k belongs to the candidate that cell k is taking in.
		assign hit_start_vec[k] = p_start;

		lsws_cell #(
			.POS_W (POS_W),
			.LAST  (k == MAX_LEN - 1)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.value      (value),
			.target     (target_q),
			.prev_act   (p_act),
			.prev_sum   (p_sum),
			.prev_start (p_start),
			.act_q      (act_vec[k]),
			.sum_q      (sum_vec[k]),
			.start_q    (start_vec[k]),
			.hit        (hit_vec[k])
		);
	end

	lsws_match_out #(
		.MAX_LEN (MAX_LEN),
		.POS_W   (POS_W)
	) u_match_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.open      (open),
		.hit_vec   (hit_vec),
		.start_vec (hit_start_vec),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

	// An older candidate always carries a strictly larger sum than a younger one.
	`LSWS_ASSERT_ALWAYS(a_single_hit, $onehot0(hit_vec))
	`LSWS_ASSERT(a_text_end_clears, accept && s_tlast |=> act_vec == '0 && pos_q == '0)
	`LSWS_ASSERT(a_result_from_request, $rose(m_tvalid) |-> $past(accept))
	`LSWS_ASSERT_ALWAYS(a_pos_in_range, pos_q <= POS_MAX)
	`LSWS_ASSERT(a_stall_freezes_chain, !open |=> $stable(act_vec) && $stable(pos_q))

endmodule

/* rtl/lsws_cell.sv */
// ----------------------------------------------------------------------------
// Letter sum window search: candidate cell
// Holds one candidate of a fixed age and passes it on, one step older.
// ----------------------------------------------------------------------------
module lsws_cell import lsws_pkg::*; #(
	parameter int POS_W = 10,
	parameter bit LAST  = 1'b0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lsws_ctl_t           ctl,
	input  logic [VAL_W-1:0]    value,
	input  logic [SUM_W-1:0]    target,
	input  logic                prev_act,
	input  logic [SUM_W-1:0]    prev_sum,
	input  logic [POS_W-1:0]    prev_start,
	output logic                act_q,
	output logic [SUM_W-1:0]    sum_q,
	output logic [POS_W-1:0]    start_q,
	output logic                hit
);

	logic [SUM_W:0] sum_next;
	logic           keep;

	assign sum_next = {1'b0, prev_sum} + (SUM_W+1)'(value);
	assign hit      = prev_act && (sum_next == {1'b0, target});
	// The oldest cell drops whatever did not match on its last character.
	assign keep     = prev_act && (sum_next < {1'b0, target}) && !LAST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else if (ctl.adv) begin
			act_q <= keep && !ctl.clr;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			sum_q   <= sum_next[SUM_W-1:0];
			start_q <= prev_start;
		end
	end

endmodule

/* rtl/lsws_match_out.sv */
// ----------------------------------------------------------------------------
// Letter sum window search: match output stage
// Selects the matching cell's start and length and holds the result.
// ----------------------------------------------------------------------------
module lsws_match_out import lsws_pkg::*; #(
	parameter int MAX_LEN = 32,
	parameter int POS_W   = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lsws_ctl_t                       ctl,
	input  logic                            open,
	input  logic [MAX_LEN-1:0]              hit_vec,
	input  logic [MAX_LEN-1:0][POS_W-1:0]   start_vec,
	output logic                            m_tvalid,
	output logic [START_W+LEN_W-1:0]        m_tdata
);

	logic                       any_hit;
	logic [POS_W-1:0]           sel_start;
	logic [LEN_W-1:0]           sel_len;
	logic [POS_W+START_W-1:0]   start_ext;
	logic                       valid_q;
	logic [START_W+LEN_W-1:0]   data_q;

	// At most one cell matches, so an AND-OR select is enough.
	always_comb begin
		sel_start = '0;
		sel_len   = '0;
		for (int k = 0; k < MAX_LEN; k++) begin
			if (hit_vec[k]) begin
				sel_start = sel_start | start_vec[k];
				sel_len   = sel_len | LEN_W'(k + 1);
			end
		end
	end

	assign any_hit   = |hit_vec;
	assign start_ext = {{START_W{1'b0}}, sel_start};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (open) begin
			valid_q <= ctl.adv && any_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (open && ctl.adv) begin
			data_q <= {sel_len, start_ext[START_W-1:0]};
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

endmodule

/* sim/lsws_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Letter sum window search checker
// Watches the configuration, request and result channels, keeps its own copy
// of the candidate window and compares every match against its prediction.
// ----------------------------------------------------------------------------
module lsws_checker import lsws_pkg::*; #(
	parameter int MAX_LEN  = 32,
	parameter int MAX_TEXT = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [SUM_W-1:0]         cfg_data,
	input  logic                     s_tvalid,
	input  logic                     s_tready,
	input  logic [CHAR_W-1:0]        s_tdata,    // [7:0] text_char
	input  logic                     s_tlast,    // end_of_text
	input  logic                     m_tvalid,
	input  logic                     m_tready,
	input  logic [START_W+LEN_W-1:0] m_tdata,    // [9:0] match_start, [15:10] match_length
	output int                       fail_cnt,
	output int                       pending,
	output int                       char_cnt,
	output int                       match_cnt
);

	// Length sits above start so that the struct lines up with m_tdata.
	typedef struct packed {
		logic [LEN_W-1:0]   len;
		logic [START_W-1:0] start;
	} match_t;

	match_t           match_q[$];
	match_t           want;
	match_t           got;
	logic [SUM_W-1:0] target;
	bit               live [MAX_LEN];
	int               total [MAX_LEN];
	int               text_pos;
	int               errs  = 0;
	int               chars = 0;
	int               hits  = 0;

	function automatic int letter_value(input logic [CHAR_W-1:0] c);
		if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
			return int'(c - CHAR_UC_A) + 1;
		end
		if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
			return int'(c - CHAR_LC_A) + 1;
		end
		return 0;
	endfunction

	// Entry k of the window is the candidate that opened k characters ago.
	task automatic scan_char(input logic [CHAR_W-1:0] c, input logic last);
		int     v;
		int     s;
		int     age;
		int     start_pos;
		bit     act;
		bit     hit;
		match_t m;
		v   = letter_value(c);
		hit = 1'b0;
		age = 0;
		for (int k = MAX_LEN - 1; k >= 0; k--) begin
			if (k == 0) begin
				act = (v != 0);
				s   = v;
			end else begin
				act = live[k-1];
				s   = total[k-1] + v;
			end
			if (act) begin
				if (s == int'(target)) begin
					hit = 1'b1;
					age = k;
					act = 1'b0;
				end else if (s > int'(target)) begin
					act = 1'b0;
				end else if (k + 1 >= MAX_LEN) begin
					act = 1'b0;
				end
			end
			live[k]  = act;
			total[k] = act ? s : 0;
		end
		if (hit) begin
			start_pos = (text_pos + MAX_TEXT - (age % MAX_TEXT)) % MAX_TEXT;
			m.start   = start_pos[START_W-1:0];
			m.len     = LEN_W'(age + 1);
			match_q.push_back(m);
		end
		if (last) begin
			for (int k = 0; k < MAX_LEN; k++) begin
				live[k]  = 1'b0;
				total[k] = 0;
			end
			text_pos = 0;
		end else begin
			text_pos = (text_pos + 1) % MAX_TEXT;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target   = '0;
			text_pos = 0;
			for (int k = 0; k < MAX_LEN; k++) begin
				live[k]  = 1'b0;
				total[k] = 0;
			end
			match_q.delete();
		end else begin
			// Results first: a request taken at this edge cannot answer before the next.
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (match_q.size() == 0) begin
					errs++;
					$display("%0t: unexpected match, expected none, got start %0d length %0d",
						$time, got.start, got.len);
				end else begin
					want = match_q.pop_front();
					hits++;
					if (got.start !== want.start) begin
						errs++;
						$display("%0t: match start mismatch, expected %0d, got %0d",
							$time, want.start, got.start);
					end
					if (got.len !== want.len) begin
						errs++;
						$display("%0t: match length mismatch, expected %0d, got %0d",
							$time, want.len, got.len);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				target = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				chars++;
				scan_char(s_tdata, s_tlast);
			end
		end
		fail_cnt  <= errs;
		pending   <= match_q.size();
		char_cnt  <= chars;
		match_cnt <= hits;
	end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Letter sum window search testbench
// Feeds directed and random text under a series of targets, with random
// idling on both streams and one long receiver hold, and relies on the
// checker for every comparison.
// ----------------------------------------------------------------------------
module tb;
	import lsws_pkg::*;

	localparam int MAX_LEN       = 32;
	localparam int MAX_TEXT      = 1024;
	localparam int N_ITEMS       = 1200;
	localparam int CALM_ITEMS    = 150;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 4;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [SUM_W-1:0]         cfg_data;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [CHAR_W-1:0]        s_tdata;     // [7:0] text_char
	logic                     s_tlast;     // end_of_text
	logic                     m_tvalid;
	logic                     m_tready;
	logic [START_W+LEN_W-1:0] m_tdata;     // [9:0] match_start, [15:10] match_length

	int               fail_cnt;
	int               pending;
	int               char_cnt;
	int               match_cnt;
	int               n_sent      = 0;
	int               since_eot   = 0;
	int               n_settings  = 0;
	int               tb_errs     = 0;
	bit               wrapped     = 1'b0;
	bit               calm        = 1'b0;
	bit               src_jitter  = 1'b1;
	bit               sink_jitter = 1'b1;
	bit               hold_req    = 1'b0;
	logic [SUM_W-1:0] tgt_now     = '0;

	always #5 clk = ~clk;

	letter_sum_window_search_core #(
		.MAX_LEN  (MAX_LEN),
		.MAX_TEXT (MAX_TEXT)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	lsws_checker #(
		.MAX_LEN  (MAX_LEN),
		.MAX_TEXT (MAX_TEXT)
	) u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.fail_cnt  (fail_cnt),
		.pending   (pending),
		.char_cnt  (char_cnt),
		.match_cnt (match_cnt)
	);

	function automatic logic [CHAR_W-1:0] letter(input int v);
		return CHAR_W'(($urandom_range(0, 1) ? CHAR_UC_A : CHAR_LC_A) + v - 1);
	endfunction

	// Any byte worth nothing: control and punctuation, the gaps between the
	// two alphabets, and everything above the lowercase range.
	function automatic logic [CHAR_W-1:0] filler();
		case ($urandom_range(0, 2))
			0: begin
				return CHAR_W'(CHAR_UC_A - 1 - $urandom_range(0, 64));
			end
			1: begin
				return CHAR_W'(CHAR_UC_Z + 1 + $urandom_range(0, 5));
			end
			default: begin
				return CHAR_W'(CHAR_LC_Z + 1 + $urandom_range(0, 132));
			end
		endcase
	endfunction

	task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
		if (src_jitter && !calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		n_sent++;
		since_eot = last ? 0 : since_eot + 1;
		if (since_eot >= MAX_TEXT) begin
			wrapped = 1'b1;
		end
	endtask

	// Text ends only once the position counter has wrapped, so one long text
	// runs through the modulo boundary first.
	task automatic put(input logic [CHAR_W-1:0] c);
		send_char(c, wrapped && $urandom_range(0, 30) == 0);
	endtask

	task automatic settle();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending != 0) begin
			tb_errs++;
			$display("%0t: %0d expected matches never arrived", $time, pending);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_target(input logic [SUM_W-1:0] t);
		cfg_valid <= 1'b1;
		cfg_data  <= t;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		tgt_now = t;
		n_settings++;
	endtask

	task automatic emit_chunk();
		int               mode;
		int               rem;
		int               v;
		logic [CHAR_W-1:0] b;
		mode = $urandom_range(0, 99);
		if (mode < 60 && tgt_now != 0) begin
			// Letters that add up to the target, now and then with fillers between.
			rem = int'(tgt_now);
			for (int n = 0; n < 40 && rem > 0; n++) begin
				if (tgt_now <= 600 && $urandom_range(0, 4) == 0) begin
					put(filler());
				end
				if (rem >= 26 && tgt_now > 600) begin
					v = 26;
				end else if (rem > 26) begin
					v = $urandom_range(1, 26);
				end else if ($urandom_range(0, 2) == 0) begin
					v = rem;
				end else begin
					v = $urandom_range(1, rem);
				end
				put(letter(v));
				rem -= v;
			end
		end else if (mode < 75 && tgt_now >= 2 && tgt_now <= 52) begin
			// Two letters around a run of fillers, so the match lands just
			// inside or just past the length limit.
			v = $urandom_range(1, (tgt_now - 1 < 26) ? tgt_now - 1 : 26);
			if (int'(tgt_now) - v > 26) begin
				v = int'(tgt_now) - 26;
			end
			put(letter(int'(tgt_now) - v));
			repeat ($urandom_range(MAX_LEN - 4, MAX_LEN)) put(filler());
			put(letter(v));
		end else begin
			repeat ($urandom_range(1, 8)) begin
				b = $urandom_range(0, 1) ? letter($urandom_range(1, 26))
					: CHAR_W'($urandom_range(0, 255));
				put(b);
			end
		end
	endtask

	task automatic run_phase(input logic [SUM_W-1:0] t, input int n_items);
		int stop_at;
		settle();
		write_target(t);
		calm        = (n_sent >= N_ITEMS - CALM_ITEMS);
		src_jitter  = ($urandom_range(0, 3) != 0);
		sink_jitter = ($urandom_range(0, 3) != 0);
		stop_at     = n_sent + n_items;
		while (n_sent < stop_at) emit_chunk();
	endtask

	// Receiver side: random stalls, plus one long hold when requested.
	initial begin
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (sink_jitter && !calm && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		#3_000_000;
		$display("%0t: run timed out", $time);
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tlast   <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With a zero target every letter overshoots at once.
		write_target('0);
		send_char(CHAR_UC_A, 1'b0);
		send_char(CHAR_LC_Z, 1'b0);
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b1);
		settle();

		write_target(10'd26);
		send_char(CHAR_UC_Z, 1'b0);    // one letter on its own
		send_char(CHAR_LC_A, 1'b0);
		send_char(8'h40, 1'b0);        // just below 'A', inside the stretch
		send_char(8'h79, 1'b0);        // 'y' closes a three-character match
		send_char(8'h5B, 1'b0);
		send_char(8'h60, 1'b0);
		send_char(8'h7B, 1'b0);
		send_char(CHAR_LC_Z, 1'b0);    // older candidate overshoots, new one hits
		send_char(8'h80, 1'b0);
		send_char(8'h6D, 1'b0);
		send_char(8'h6D, 1'b0);
		send_char(8'h4D, 1'b0);        // overlapping pairs of 'm'
		send_char(8'h62, 1'b1);        // open candidate dropped at end of text
		send_char(8'h78, 1'b0);
		send_char(8'h62, 1'b0);        // match starting at position zero again

		run_phase(10'd1023, 100);
		run_phase(10'd0, 100);
		run_phase(10'd1, 80);
		// Every letter matches now; hold the receiver so the block backs up.
		hold_req = 1'b1;
		repeat (40) put(letter(1));
		run_phase(10'd832, 110);
		run_phase(SUM_W'($urandom_range(2, 52)), 110);
		run_phase(SUM_W'($urandom_range(53, 300)), 110);
		run_phase(SUM_W'($urandom_range(301, 1023)), 100);
		run_phase(10'd52, 110);
		run_phase(10'd2, 110);
		run_phase(SUM_W'($urandom_range(2, 26)), 110);
		run_phase(SUM_W'($urandom_range(0, 1023)), 110);
		settle();

		$display("Sent %0d characters under %0d target settings, %0d matches checked.",
			char_cnt, n_settings, match_cnt);
		$display("Position wrap %0s; one receiver hold of %0d cycles applied.",
			wrapped ? "reached" : "not reached", HOLD_CYCLES);
		if (fail_cnt == 0 && tb_errs == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
